FILE: rtl/core/mcdd_pkg.sv
// Shared constants for the multiplexed clock display driver.
// No dependencies; compiled first.
package mcdd_pkg;

   localparam int NUM_DIGITS_DEF = 4;
   localparam int NUM_ROWS_DEF   = 8;

   localparam int PERIOD_W = 8;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIGIT_PERIOD  = 2'd0,
      CSR_CLOCK_PERIOD  = 2'd1,
      CSR_MATRIX_PERIOD = 2'd2
   } csr_index_type;

   localparam logic [PERIOD_W-1:0] DIGIT_PERIOD_RST  = 8'd25;
   localparam logic [PERIOD_W-1:0] CLOCK_PERIOD_RST  = 8'd100;
   localparam logic [PERIOD_W-1:0] MATRIX_PERIOD_RST = 8'd15;

   localparam logic [4:0] HOUR_RST   = 5'd15;
   localparam logic [5:0] MINUTE_RST = 6'd8;
   localparam logic [5:0] SECOND_RST = 6'd50;

   localparam logic [5:0] SEC_PER_MIN  = 6'd60;
   localparam logic [5:0] MIN_PER_HOUR = 6'd60;
   localparam logic [4:0] HOUR_PER_DAY = 5'd24;

   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam int         CLOCK_DIGITS = 4;
   localparam int         DRIVE_DIGITS = 4;
   localparam int         DRIVE_ROWS   = 8;

   typedef logic [6:0] seg_type;
   typedef logic [7:0] row_pat_type;

   localparam seg_type SEG_TABLE [10] = '{
      7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
   };

   localparam logic [3:0] DIGIT_RST [CLOCK_DIGITS] = '{4'd1, 4'd5, 4'd0, 4'd8};

   localparam row_pat_type IMAGE_RST [8] = '{
      8'h18, 8'h3C, 8'h66, 8'h66, 8'h7E, 8'h7E, 8'h66, 8'h66
   };

endpackage

FILE: rtl/core/mcdd_channels.sv
// Valid/ready channel interfaces for the display driver request and response.
// Depends on nothing; compiled after mcdd_pkg.
interface mcdd_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

interface mcdd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] digit_enable_n;
   logic [6:0] segments_n;
   logic [7:0] row_enable_n;
   logic [7:0] columns_n;
   logic       blink_led;
   logic [4:0] hours;
   logic [5:0] minutes;
   logic [5:0] seconds;

   modport source (output valid, output digit_enable_n, output segments_n,
                   output row_enable_n, output columns_n, output blink_led,
                   output hours, output minutes, output seconds, input ready);
   modport sink   (input valid, input digit_enable_n, input segments_n,
                   input row_enable_n, input columns_n, input blink_led,
                   input hours, input minutes, input seconds, output ready);
endinterface

FILE: rtl/core/multiplexed_clock_display_driver_top.sv
// Multiplexed clock display driver: digit scan, hh:mm:ss clock, LED matrix scan.
// Depends on mcdd_pkg and the channel interfaces in mcdd_channels.sv.
//
// Each transferred request carries one tick bit; a tick of 1 advances the digit,
// clock and matrix countdowns, a tick of 0 changes nothing. Every request yields
// exactly one response, which shows the display latches and the time after the
// update and appears the cycle after the request transfer. All state updates at
// once, and the state registers double as the response register, so a
// request can transfer every cycle: intake stalls only while a response is held
// and rsp_chan.ready is low. Period registers are written through the csr port;
// a period of 0 acts as 1 and a new period takes effect at the next reload.
module multiplexed_clock_display_driver_top #(
   parameter int NUM_DIGITS = mcdd_pkg::NUM_DIGITS_DEF,
   parameter int NUM_ROWS   = mcdd_pkg::NUM_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   mcdd_req_if.sink                      req_chan,
   mcdd_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [mcdd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcdd_pkg::PERIOD_W-1:0]  csr_wdata
);
   import mcdd_pkg::*;

   localparam int DIG_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int ROW_IDX_W = $clog2(NUM_ROWS);

   function automatic logic [3:0] tens_of(input logic [5:0] v);
      logic [3:0] t;
      if (v >= 6'd50)      t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else                 t = 4'd0;
      return t;
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] v, input logic [3:0] t);
      logic [5:0] r;
      r = v - {t[2:0], 3'b000} - {1'b0, t, 1'b0};
      return r[3:0];
   endfunction

   function automatic logic [PERIOD_W-1:0] reload(input logic [PERIOD_W-1:0] p);
      return (p == '0) ? PERIOD_W'(1) : p;
   endfunction

   // configuration
   logic [PERIOD_W-1:0] digit_period_ff, clock_period_ff, matrix_period_ff;

   // timing and display state
   logic [PERIOD_W-1:0] digit_cd_ff, clock_cd_ff, matrix_cd_ff;
   logic [PERIOD_W-1:0] digit_cd_in, clock_cd_in, matrix_cd_in;
   logic [DIG_IDX_W-1:0] digit_idx_ff, digit_idx_in;
   logic [3:0]           digit_store_ff [NUM_DIGITS];
   logic [3:0]           digit_store_in [NUM_DIGITS];
   logic [4:0]           hour_ff, hour_in;
   logic [5:0]           minute_ff, minute_in;
   logic [5:0]           second_ff, second_in;
   logic [ROW_IDX_W-1:0] row_idx_ff, row_idx_in;
   row_pat_type          image_ff [NUM_ROWS];
   row_pat_type          image_in [NUM_ROWS];
   logic [3:0]           dig_en_n_ff, dig_en_n_in;
   seg_type              seg_n_ff, seg_n_in;
   logic [7:0]           row_en_n_ff, row_en_n_in;
   logic [7:0]           col_n_ff, col_n_in;
   logic                 blink_ff, blink_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic       accept, step;
   logic       digit_exp, clock_exp, matrix_exp;
   logic [3:0] digit_val;
   logic [6:0] sec_sum;
   logic       sec_wrap;
   logic [6:0] min_sum;
   logic       min_wrap;
   logic [5:0] hour_sum;
   logic [3:0] split [CLOCK_DIGITS];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign step   = accept && req_chan.tick;

   assign digit_exp  = digit_cd_ff  <= PERIOD_W'(1);
   assign clock_exp  = clock_cd_ff  <= PERIOD_W'(1);
   assign matrix_exp = matrix_cd_ff <= PERIOD_W'(1);

   always_comb begin
      // countdowns
      digit_cd_in  = digit_cd_ff;
      clock_cd_in  = clock_cd_ff;
      matrix_cd_in = matrix_cd_ff;
      if (step) begin
         digit_cd_in  = digit_exp  ? reload(digit_period_ff)  : digit_cd_ff - 1'b1;
         clock_cd_in  = clock_exp  ? reload(clock_period_ff)  : clock_cd_ff - 1'b1;
         matrix_cd_in = matrix_exp ? reload(matrix_period_ff) : matrix_cd_ff - 1'b1;
      end

      // digit scan, reads the store before any clock reload
      digit_idx_in = digit_idx_ff;
      dig_en_n_in  = dig_en_n_ff;
      seg_n_in     = seg_n_ff;
      digit_val    = digit_store_ff[digit_idx_ff];
      if (digit_val > DIGIT_MAX)
         digit_val = DIGIT_MAX;
      if (step && digit_exp) begin
         seg_n_in = SEG_TABLE[digit_val];
         for (int k = 0; k < DRIVE_DIGITS; k++)
            dig_en_n_in[k] = !((k < NUM_DIGITS) && (32'(digit_idx_ff) == k));
         if (digit_idx_ff == DIG_IDX_W'(NUM_DIGITS - 1))
            digit_idx_in = '0;
         else
            digit_idx_in = digit_idx_ff + 1'b1;
      end

      // clock
      sec_sum  = {1'b0, second_ff} + 7'd1;
      sec_wrap = sec_sum >= {1'b0, SEC_PER_MIN};
      min_sum  = {1'b0, minute_ff} + {6'd0, sec_wrap};
      min_wrap = min_sum >= {1'b0, MIN_PER_HOUR};
      hour_sum = {1'b0, hour_ff} + {5'd0, min_wrap};
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      blink_in  = blink_ff;
      if (step && clock_exp) begin
         blink_in  = !blink_ff;
         second_in = sec_wrap ? 6'd0 : sec_sum[5:0];
         minute_in = min_wrap ? 6'd0 : min_sum[5:0];
         hour_in   = (hour_sum >= {1'b0, HOUR_PER_DAY}) ? 5'd0 : hour_sum[4:0];
      end
      split[0] = tens_of({1'b0, hour_in});
      split[1] = units_of({1'b0, hour_in}, split[0]);
      split[2] = tens_of(minute_in);
      split[3] = units_of(minute_in, split[2]);
      for (int k = 0; k < NUM_DIGITS; k++) begin
         digit_store_in[k] = digit_store_ff[k];
         if (step && clock_exp && (k < CLOCK_DIGITS))
            digit_store_in[k] = split[k[1:0]];
      end

      // matrix scan
      row_idx_in  = row_idx_ff;
      row_en_n_in = row_en_n_ff;
      col_n_in    = col_n_ff;
      for (int k = 0; k < NUM_ROWS; k++)
         image_in[k] = image_ff[k];
      if (step && matrix_exp) begin
         col_n_in = ~image_ff[row_idx_ff];
         for (int k = 0; k < DRIVE_ROWS; k++)
            row_en_n_in[k] = !((k < NUM_ROWS) && (32'(row_idx_ff) == k));
         if (row_idx_ff == ROW_IDX_W'(NUM_ROWS - 1)) begin
            row_idx_in = '0;
            for (int k = 0; k < NUM_ROWS - 1; k++)
               image_in[k] = image_ff[k + 1];
            image_in[NUM_ROWS - 1] = image_ff[0];
         end else begin
            row_idx_in = row_idx_ff + 1'b1;
         end
      end

      // response holds until taken
      if (accept)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_period_ff  <= DIGIT_PERIOD_RST;
         clock_period_ff  <= CLOCK_PERIOD_RST;
         matrix_period_ff <= MATRIX_PERIOD_RST;
         digit_cd_ff      <= DIGIT_PERIOD_RST;
         clock_cd_ff      <= CLOCK_PERIOD_RST;
         matrix_cd_ff     <= MATRIX_PERIOD_RST;
         digit_idx_ff     <= '0;
         for (int k = 0; k < NUM_DIGITS; k++)
            digit_store_ff[k] <= (k < CLOCK_DIGITS) ? DIGIT_RST[k[1:0]] : 4'd0;
         hour_ff          <= HOUR_RST;
         minute_ff        <= MINUTE_RST;
         second_ff        <= SECOND_RST;
         row_idx_ff       <= '0;
         for (int k = 0; k < NUM_ROWS; k++)
            image_ff[k] <= IMAGE_RST[k[2:0]];
         dig_en_n_ff      <= '0;
         seg_n_ff         <= '0;
         row_en_n_ff      <= '0;
         col_n_ff         <= '0;
         blink_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DIGIT_PERIOD:  digit_period_ff  <= csr_wdata;
               CSR_CLOCK_PERIOD:  clock_period_ff  <= csr_wdata;
               CSR_MATRIX_PERIOD: matrix_period_ff <= csr_wdata;
               default: ;
            endcase
         end
         digit_cd_ff  <= digit_cd_in;
         clock_cd_ff  <= clock_cd_in;
         matrix_cd_ff <= matrix_cd_in;
         digit_idx_ff <= digit_idx_in;
         for (int k = 0; k < NUM_DIGITS; k++)
            digit_store_ff[k] <= digit_store_in[k];
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         row_idx_ff   <= row_idx_in;
         for (int k = 0; k < NUM_ROWS; k++)
            image_ff[k] <= image_in[k];
         dig_en_n_ff  <= dig_en_n_in;
         seg_n_ff     <= seg_n_in;
         row_en_n_ff  <= row_en_n_in;
         col_n_ff     <= col_n_in;
         blink_ff     <= blink_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.digit_enable_n = dig_en_n_ff;
   assign rsp_chan.segments_n     = seg_n_ff;
   assign rsp_chan.row_enable_n   = row_en_n_ff;
   assign rsp_chan.columns_n      = col_n_ff;
   assign rsp_chan.blink_led      = blink_ff;
   assign rsp_chan.hours          = hour_ff;
   assign rsp_chan.minutes        = minute_ff;
   assign rsp_chan.seconds        = second_ff;

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (second_ff < SEC_PER_MIN) && (minute_ff < MIN_PER_HOUR) && (hour_ff < HOUR_PER_DAY))
      else $error("clock state out of range");

   // enable latches read all zero until their first scan
   a_digit_onehot: assert property (@(posedge clock) disable iff (reset)
      ((dig_en_n_ff == '0) || ($countones(~dig_en_n_ff) <= 1))
      && ((row_en_n_ff == '0) || ($countones(~row_en_n_ff) <= 1)))
      else $error("more than one digit or row enabled");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      accept && !req_chan.tick |=> $stable(seg_n_ff) && $stable(col_n_ff)
         && $stable(second_ff) && $stable(blink_ff) && rsp_valid_ff)
      else $error("tick of zero changed state");

   a_blink_second: assert property (@(posedge clock) disable iff (reset)
      !$stable(second_ff) |-> !$stable(blink_ff))
      else $error("second advanced without blink toggle");

endmodule
